// ===== sv/rgb_triple_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_triple_line_parser_assert.svh
// Assertion macros shared by the checker of the colour line parser.
// ----------------------------------------------------------------------------
`ifndef RGB_TRIPLE_LINE_PARSER_ASSERT_SVH
`define RGB_TRIPLE_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while reset is active.
`define RGBTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while reset is active.
`define RGBTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rgbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbtp_pkg
// Types and constants of the colour line parser.
// ----------------------------------------------------------------------------
package rgbtp_pkg;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_PRE_DIGIT  = 3'd1,
        PH_IN_DIGITS  = 3'd2,
        PH_PRE_COMMA  = 3'd3,
        PH_TRAILING   = 3'd4,
        PH_DROP       = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FLOOR    = 2'd0,
        KIND_CEILING  = 2'd1,
        KIND_NOT_LINE = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    localparam logic [7:0]  CH_NUL     = 8'd0;
    localparam logic [7:0]  CH_TAB     = 8'd9;
    localparam logic [7:0]  CH_NEWLINE = 8'd10;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [7:0]  CH_COMMA   = 8'd44;
    localparam logic [7:0]  CH_ZERO    = 8'd48;
    localparam logic [7:0]  CH_NINE    = 8'd57;
    localparam logic [7:0]  CH_UPPER_C = 8'd67;
    localparam logic [7:0]  CH_UPPER_F = 8'd70;
    localparam logic [11:0] VALUE_MAX  = 12'd255;
    localparam logic [1:0]  LAST_COMPONENT = 2'd2;

    typedef struct packed {
        logic       is_blank;
        logic       is_end;
        logic       is_digit;
        logic       is_comma;
        logic       is_f;
        logic       is_c;
        logic [3:0] digit;
    } byte_class_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

endpackage

// ===== sv/rgb_triple_line_parser.sv =====
// ----------------------------------------------------------------------------
// rgb_triple_line_parser
// Byte-serial parser for floor and ceiling colour lines of a map file.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Signals                    | Meaning
//  --------+-----+----------------------------+-------------------------------
//  s_*     | in  | tvalid, tready, tdata[7:0] | one text byte per word
//  m_*     | out | tvalid, tready, tdata,tuser| one result word per line
//
//  The block takes one byte every cycle while s_tready is high. Each accepted
//  byte is classified and stepped through the parser state machine in the same
//  cycle; a decided line writes its result into a two-entry output buffer,
//  which is what the master side reads, and m_tvalid rises in the cycle after
//  the deciding byte. s_tready drops only while both buffer entries hold
//  results that the downstream side has not taken. rst_n clears the parser to
//  the start of a line and empties the buffer.
//
// ----------------------------------------------------------------------------
module rgb_triple_line_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic [1:0]  m_tuser    // [1:0] kind
);

    rgbtp_pkg::byte_class_t cls;
    rgbtp_pkg::result_t     core_res;
    rgbtp_pkg::result_t     buf_res;
    logic                   core_res_valid;
    logic                   buf_full;
    logic                   accept;

    // Any word may cause a result, so input waits whenever the buffer is full.
    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;

    rgbtp_classify u_classify
    (
        .ch  (s_tdata),
        .cls (cls)
    );

    rgbtp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cls       (cls),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    rgbtp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_res_valid),
        .push_data (core_res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_res)
    );

    // Kind travels on tuser, the three components on tdata.
    assign m_tuser = buf_res.kind;
    assign m_tdata = {buf_res.blue, buf_res.green, buf_res.red};

endmodule

// ===== sv/rgbtp_classify.sv =====
// ----------------------------------------------------------------------------
// rgbtp_classify
// Sorts one text byte into the character classes the parser needs.
// ----------------------------------------------------------------------------
module rgbtp_classify
(
    input  logic [7:0]           ch,
    output rgbtp_pkg::byte_class_t cls
);

    always_comb
    begin
        cls.is_blank = (ch == rgbtp_pkg::CH_SPACE) || (ch == rgbtp_pkg::CH_TAB);
        cls.is_end   = (ch == rgbtp_pkg::CH_NUL) || (ch == rgbtp_pkg::CH_NEWLINE);
        cls.is_digit = (ch >= rgbtp_pkg::CH_ZERO) && (ch <= rgbtp_pkg::CH_NINE);
        cls.is_comma = (ch == rgbtp_pkg::CH_COMMA);
        cls.is_f     = (ch == rgbtp_pkg::CH_UPPER_F);
        cls.is_c     = (ch == rgbtp_pkg::CH_UPPER_C);
        // ASCII digits sit at 0x30..0x39, so the low nibble is the value.
        cls.digit    = ch[3:0];
    end

endmodule

// ===== sv/rgbtp_core.sv =====
// ----------------------------------------------------------------------------
// rgbtp_core
// Parser state machine: consumes one classified byte per accepted word and
// raises a result when a line is decided.
// ----------------------------------------------------------------------------
module rgbtp_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  rgbtp_pkg::byte_class_t cls,
    output logic                   res_valid,
    output rgbtp_pkg::result_t     res
);

    rgbtp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]        comp_idx_reg, comp_idx_next;
    logic [7:0]        acc_reg, acc_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic              ceil_reg, ceil_next;

    logic [11:0] acc_sum;
    logic        more_comps;
    logic        do_fail;
    logic        do_succeed;
    logic        do_next;
    logic        do_not_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rgbtp_pkg::PH_LINE_START;
            comp_idx_reg <= 2'd0;
            acc_reg      <= 8'd0;
            first_reg    <= 8'd0;
            second_reg   <= 8'd0;
            ceil_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            comp_idx_reg <= comp_idx_next;
            acc_reg      <= acc_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            ceil_reg     <= ceil_next;
        end
    end

    always_comb
    begin
        // Running value times ten plus the new digit, as two shifts and adds.
        acc_sum = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {8'd0, cls.digit};
        more_comps = (comp_idx_reg < rgbtp_pkg::LAST_COMPONENT);

        phase_next    = phase_reg;
        comp_idx_next = comp_idx_reg;
        acc_next      = acc_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        ceil_next     = ceil_reg;
        do_fail       = 1'b0;
        do_succeed    = 1'b0;
        do_next       = 1'b0;
        do_not_line   = 1'b0;

        case (phase_reg)
            rgbtp_pkg::PH_LINE_START:
            begin
                if (cls.is_f || cls.is_c)
                begin
                    ceil_next     = cls.is_c;
                    comp_idx_next = 2'd0;
                    acc_next      = 8'd0;
                    phase_next    = rgbtp_pkg::PH_PRE_DIGIT;
                end
                else
                begin
                    do_not_line = 1'b1;
                    phase_next  = cls.is_end ? rgbtp_pkg::PH_LINE_START : rgbtp_pkg::PH_DROP;
                end
            end
            rgbtp_pkg::PH_PRE_DIGIT:
            begin
                if (cls.is_digit)
                begin
                    acc_next   = {4'd0, cls.digit};
                    phase_next = rgbtp_pkg::PH_IN_DIGITS;
                end
                else if (!cls.is_blank)
                begin
                    do_fail = 1'b1;
                end
            end
            rgbtp_pkg::PH_IN_DIGITS:
            begin
                if (cls.is_digit)
                begin
                    if (acc_sum > rgbtp_pkg::VALUE_MAX)
                        do_fail = 1'b1;
                    else
                        acc_next = acc_sum[7:0];
                end
                else if (cls.is_blank)
                begin
                    phase_next = more_comps ? rgbtp_pkg::PH_PRE_COMMA : rgbtp_pkg::PH_TRAILING;
                end
                else if (cls.is_comma && more_comps)
                begin
                    do_next = 1'b1;
                end
                else if (cls.is_end && !more_comps)
                begin
                    do_succeed = 1'b1;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            rgbtp_pkg::PH_PRE_COMMA:
            begin
                if (cls.is_comma)
                    do_next = 1'b1;
                else if (!cls.is_blank)
                    do_fail = 1'b1;
            end
            rgbtp_pkg::PH_TRAILING:
            begin
                if (cls.is_end)
                    do_succeed = 1'b1;
                else if (!cls.is_blank)
                    do_fail = 1'b1;
            end
            default:
            begin
                // Drop phase, and any unused code: wait for the line end.
                if (cls.is_end)
                    phase_next = rgbtp_pkg::PH_LINE_START;
            end
        endcase

        if (do_next)
        begin
            if (comp_idx_reg == 2'd0)
                first_next = acc_reg;
            else
                second_next = acc_reg;
            comp_idx_next = comp_idx_reg + 2'd1;
            acc_next      = 8'd0;
            phase_next    = rgbtp_pkg::PH_PRE_DIGIT;
        end

        if (do_fail)
            phase_next = cls.is_end ? rgbtp_pkg::PH_LINE_START : rgbtp_pkg::PH_DROP;

        if (do_succeed)
            phase_next = rgbtp_pkg::PH_LINE_START;

        res_valid = accept && (do_fail || do_succeed || do_not_line);
        res.kind  = rgbtp_pkg::KIND_ERROR;
        res.red   = 8'd0;
        res.green = 8'd0;
        res.blue  = 8'd0;
        if (do_not_line)
        begin
            res.kind = rgbtp_pkg::KIND_NOT_LINE;
        end
        else if (do_succeed)
        begin
            res.kind  = ceil_reg ? rgbtp_pkg::KIND_CEILING : rgbtp_pkg::KIND_FLOOR;
            res.red   = first_reg;
            res.green = second_reg;
            res.blue  = acc_reg;
        end
    end

endmodule

// ===== sv/rgbtp_out_buf.sv =====
// ----------------------------------------------------------------------------
// rgbtp_out_buf
// Two-entry result buffer that separates the parser from the output stall.
// ----------------------------------------------------------------------------
module rgbtp_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rgbtp_pkg::result_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output rgbtp_pkg::result_t out_data
);

    rgbtp_pkg::result_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        out_valid   = (count_reg != 2'd0);
        full        = (count_reg == 2'd2);
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        out_data    = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/rgbtp_checker.sv =====
// ----------------------------------------------------------------------------
// rgbtp_checker
// Port-level checks of the colour line parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_triple_line_parser_assert.svh"

module rgbtp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic m_stall;
    logic bad_kind;

    assign m_stall  = m_tvalid && !m_tready;
    assign bad_kind = (m_tuser == rgbtp_pkg::KIND_NOT_LINE)
                   || (m_tuser == rgbtp_pkg::KIND_ERROR);

    // A stalled result word stays offered.
    `RGBTP_ASSERT_NEXT(a_stall_holds_valid, m_stall, m_tvalid, "result dropped while stalled")

    // A stalled result word does not change.
    `RGBTP_ASSERT_NEXT(a_stall_holds_word, m_stall, $stable({m_tuser, m_tdata}), "word changed")

    // Error and not-a-colour results carry zero components.
    `RGBTP_ASSERT_NOW(a_zero_on_reject, m_tvalid && bad_kind, m_tdata == 24'd0, "data on reject")

    // Input is held off only while results wait on the output.
    `RGBTP_ASSERT_NOW(a_ready_low_needs_output, !s_tready, m_tvalid, "input stall while empty")

endmodule

bind rgb_triple_line_parser rgbtp_checker u_rgbtp_checker (.*);
